[hdl/m68kdx_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package m68kdx_pkg;

  // Architectural sizes
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned OP_W      = 16;
  localparam int unsigned FLAG_W    = 5;
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned REG_IDX_W = $clog2(NUM_REGS);

  // Flag bit positions in the condition register
  localparam int unsigned FLAG_X_BIT = 4;
  localparam int unsigned FLAG_N_BIT = 3;
  localparam int unsigned FLAG_Z_BIT = 2;
  localparam int unsigned FLAG_V_BIT = 1;
  localparam int unsigned FLAG_C_BIT = 0;

  // Opcode constants
  localparam logic [OP_W-1:0] OPC_NOP = 16'h4E71;

  localparam logic [3:0] GRP_BCC   = 4'h6;
  localparam logic [3:0] GRP_MOVEQ = 4'h7;
  localparam logic [3:0] GRP_MOVEL = 4'h2;
  localparam logic [3:0] GRP_OR    = 4'h8;
  localparam logic [3:0] GRP_SUB   = 4'h9;
  localparam logic [3:0] GRP_CMPEOR = 4'hB;
  localparam logic [3:0] GRP_AND   = 4'hC;
  localparam logic [3:0] GRP_ADD   = 4'hD;

  localparam logic [2:0] OPMODE_MOVE = 3'd0;
  localparam logic [2:0] OPMODE_LONG = 3'd2;
  localparam logic [2:0] OPMODE_EOR  = 3'd6;
  localparam logic [2:0] EAMODE_DREG = 3'd0;

  localparam logic [3:0] CC_T   = 4'h0;
  localparam logic [3:0] CC_F   = 4'h1;
  localparam logic [3:0] CC_HI  = 4'h2;
  localparam logic [3:0] CC_LS  = 4'h3;
  localparam logic [3:0] CC_CC  = 4'h4;
  localparam logic [3:0] CC_CS  = 4'h5;
  localparam logic [3:0] CC_NE  = 4'h6;
  localparam logic [3:0] CC_EQ  = 4'h7;
  localparam logic [3:0] CC_VC  = 4'h8;
  localparam logic [3:0] CC_VS  = 4'h9;
  localparam logic [3:0] CC_PL  = 4'hA;
  localparam logic [3:0] CC_MI  = 4'hB;
  localparam logic [3:0] CC_GE  = 4'hC;
  localparam logic [3:0] CC_LT  = 4'hD;
  localparam logic [3:0] CC_GT  = 4'hE;

  localparam logic [7:0] DISP_WORD = 8'h00;
  localparam logic [7:0] DISP_LONG = 8'hFF;

  // Decoded instruction class
  typedef enum logic [3:0] {
    INS_NOP,
    INS_MOVEQ,
    INS_MOVE,
    INS_ADD,
    INS_SUB,
    INS_CMP,
    INS_EOR,
    INS_AND,
    INS_OR,
    INS_BCC,
    INS_ILLEGAL
  } ins_class_e;

  // Result of one executed instruction
  typedef struct packed {
    logic [DATA_W-1:0] next_pc;
    logic              branch_taken;
    logic [DATA_W-1:0] written_value;
    logic [FLAG_W-1:0] flags;
    logic              unsupported;
  } ex_result_t;

  // Register file write request
  typedef struct packed {
    logic                 en;
    logic [REG_IDX_W-1:0] idx;
    logic [DATA_W-1:0]    data;
  } rf_write_t;

  // Branch condition evaluation on the current flags
  function automatic logic cond_true(input logic [3:0] cc, input logic [FLAG_W-1:0] f);
    logic c;
    logic v;
    logic z;
    logic n;
    logic res;
    c = f[FLAG_C_BIT];
    v = f[FLAG_V_BIT];
    z = f[FLAG_Z_BIT];
    n = f[FLAG_N_BIT];
    case (cc)
      CC_T:    res = 1'b1;
      CC_F:    res = 1'b0;
      CC_HI:   res = !c && !z;
      CC_LS:   res = c || z;
      CC_CC:   res = !c;
      CC_CS:   res = c;
      CC_NE:   res = !z;
      CC_EQ:   res = z;
      CC_VC:   res = !v;
      CC_VS:   res = v;
      CC_PL:   res = !n;
      CC_MI:   res = n;
      CC_GE:   res = (n == v);
      CC_LT:   res = (n != v);
      CC_GT:   res = !z && (n == v);
      default: res = z || (n != v);
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

[hdl/m68kdx_exec.sv]
`timescale 1ns / 1ps
`default_nettype none

// Decode and execute of one instruction word: purely combinational
module m68kdx_exec import m68kdx_pkg::*; (
  input  wire logic [OP_W-1:0]   opcode_i,
  input  wire logic [DATA_W-1:0] instr_address_i,
  input  wire logic [DATA_W-1:0] dst_val_i,
  input  wire logic [DATA_W-1:0] src_val_i,
  input  wire logic [FLAG_W-1:0] flags_i,
  output ex_result_t             result_o,
  output rf_write_t              rf_wr_o
);

  logic [3:0]           group;
  logic [REG_IDX_W-1:0] rhi;
  logic [REG_IDX_W-1:0] rlo;
  logic [2:0]           opmode;
  logic [2:0]           eamode;
  logic [3:0]           cc;
  logic [7:0]           disp;
  logic [DATA_W-1:0]    disp_sx;
  logic [DATA_W-1:0]    pc2;
  ins_class_e           ins;

  logic [DATA_W:0]      add_full;
  logic [DATA_W:0]      sub_full;
  logic [DATA_W-1:0]    add_r;
  logic [DATA_W-1:0]    sub_r;
  logic                 add_v;
  logic                 sub_v;
  logic                 xkeep;

  assign group   = opcode_i[15:12];
  assign rhi     = opcode_i[11:9];
  assign rlo     = opcode_i[2:0];
  assign opmode  = opcode_i[8:6];
  assign eamode  = opcode_i[5:3];
  assign cc      = opcode_i[11:8];
  assign disp    = opcode_i[7:0];
  assign disp_sx = {{(DATA_W-8){disp[7]}}, disp};
  assign pc2     = instr_address_i + DATA_W'(2);
  assign xkeep   = flags_i[FLAG_X_BIT];

  // Instruction classification, in priority order
  always_comb begin
    if (opcode_i == OPC_NOP) begin
      ins = INS_NOP;
    end else if (group == GRP_MOVEQ && !opcode_i[8]) begin
      ins = INS_MOVEQ;
    end else if (group == GRP_MOVEL && eamode == EAMODE_DREG && opmode == OPMODE_MOVE) begin
      ins = INS_MOVE;
    end else if (group == GRP_ADD && opmode == OPMODE_LONG && eamode == EAMODE_DREG) begin
      ins = INS_ADD;
    end else if (group == GRP_SUB && opmode == OPMODE_LONG && eamode == EAMODE_DREG) begin
      ins = INS_SUB;
    end else if (group == GRP_CMPEOR && opmode == OPMODE_LONG && eamode == EAMODE_DREG) begin
      ins = INS_CMP;
    end else if (group == GRP_CMPEOR && opmode == OPMODE_EOR && eamode == EAMODE_DREG) begin
      ins = INS_EOR;
    end else if (group == GRP_AND && opmode == OPMODE_LONG && eamode == EAMODE_DREG) begin
      ins = INS_AND;
    end else if (group == GRP_OR && opmode == OPMODE_LONG && eamode == EAMODE_DREG) begin
      ins = INS_OR;
    end else if (group == GRP_BCC && disp != DISP_WORD && disp != DISP_LONG && cc != CC_F) begin
      ins = INS_BCC;
    end else begin
      ins = INS_ILLEGAL;
    end
  end

  // Adder and subtractor with carry/borrow out
  assign add_full = {1'b0, dst_val_i} + {1'b0, src_val_i};
  assign sub_full = {1'b0, dst_val_i} - {1'b0, src_val_i};
  assign add_r    = add_full[DATA_W-1:0];
  assign sub_r    = sub_full[DATA_W-1:0];
  assign add_v    = ~(dst_val_i[DATA_W-1] ^ src_val_i[DATA_W-1])
                    & (dst_val_i[DATA_W-1] ^ add_r[DATA_W-1]);
  assign sub_v    = (dst_val_i[DATA_W-1] ^ src_val_i[DATA_W-1])
                    & (dst_val_i[DATA_W-1] ^ sub_r[DATA_W-1]);

  // Result, flags and register write
  always_comb begin
    logic [DATA_W-1:0] val;
    val = '0;
    result_o.next_pc       = pc2;
    result_o.branch_taken  = 1'b0;
    result_o.written_value = '0;
    result_o.flags         = flags_i;
    result_o.unsupported   = 1'b0;
    rf_wr_o.en             = 1'b0;
    rf_wr_o.idx            = rhi;
    rf_wr_o.data           = '0;

    case (ins)
      INS_NOP: begin
      end
      INS_MOVEQ, INS_MOVE, INS_AND, INS_OR, INS_EOR: begin
        case (ins)
          INS_MOVEQ: val = disp_sx;
          INS_MOVE:  val = src_val_i;
          INS_AND:   val = dst_val_i & src_val_i;
          INS_OR:    val = dst_val_i | src_val_i;
          default:   val = dst_val_i ^ src_val_i;
        endcase
        result_o.written_value = val;
        result_o.flags = {xkeep, val[DATA_W-1], (val == '0), 1'b0, 1'b0};
        rf_wr_o.en   = 1'b1;
        rf_wr_o.idx  = (ins == INS_EOR) ? rlo : rhi;
        rf_wr_o.data = val;
      end
      INS_ADD: begin
        result_o.written_value = add_r;
        result_o.flags = {add_full[DATA_W], add_r[DATA_W-1], (add_r == '0), add_v,
                          add_full[DATA_W]};
        rf_wr_o.en   = 1'b1;
        rf_wr_o.data = add_r;
      end
      INS_SUB: begin
        result_o.written_value = sub_r;
        result_o.flags = {sub_full[DATA_W], sub_r[DATA_W-1], (sub_r == '0), sub_v,
                          sub_full[DATA_W]};
        rf_wr_o.en   = 1'b1;
        rf_wr_o.data = sub_r;
      end
      INS_CMP: begin
        result_o.flags = {xkeep, sub_r[DATA_W-1], (sub_r == '0), sub_v, sub_full[DATA_W]};
      end
      INS_BCC: begin
        if (cond_true(cc, flags_i)) begin
          result_o.branch_taken = 1'b1;
          result_o.next_pc      = pc2 + disp_sx;
        end
      end
      default: begin
        result_o.unsupported = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/m68k_subset_decode_execute_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  | handshake                   | payload
// ---------+-----------------------------+------------------------------------------
// input    | in_valid_i / in_ready_o     | opcode_i, instr_address_i
// output   | out_valid_o / out_ready_i   | next_pc_o, branch_taken_o, written_value_o,
//          |                             | flags_out_o, unsupported_o
//
// One instruction per cycle sustained while the output is not stalled.
// Stage 1 holds the opcode and both register operands, read at acceptance with a
// bypass from the instruction executing in that cycle; execute runs into the result
// register. Reset clears all data registers (per-entry valid bits) and the flags.
// A stalled output holds the result; input is still taken when the result moves on.
module m68k_subset_decode_execute_core import m68kdx_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [OP_W-1:0]   opcode_i,
  input  wire logic [DATA_W-1:0] instr_address_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [DATA_W-1:0]      next_pc_o,
  output logic                   branch_taken_o,
  output logic [DATA_W-1:0]      written_value_o,
  output logic [FLAG_W-1:0]      flags_out_o,
  output logic                   unsupported_o
);

  // Stage 1: instruction inputs and operands
  logic                 s1_valid_q;
  logic [OP_W-1:0]      s1_opcode_q;
  logic [DATA_W-1:0]    s1_addr_q;
  logic [DATA_W-1:0]    s1_dst_q;
  logic [DATA_W-1:0]    s1_src_q;

  // Architectural state
  logic [DATA_W-1:0]    rf_mem [NUM_REGS];
  logic [NUM_REGS-1:0]  rf_vld_q;
  logic [FLAG_W-1:0]    flags_q;

  // Result register
  logic                 out_valid_q;
  ex_result_t           out_res_q;

  ex_result_t           ex_res;
  rf_write_t            rf_wr;
  logic                 ex_fire;
  logic                 in_fire;
  logic [REG_IDX_W-1:0] rd_dst_idx;
  logic [REG_IDX_W-1:0] rd_src_idx;

  assign ex_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || ex_fire;
  assign in_fire    = in_valid_i && in_ready_o;
  assign rd_dst_idx = opcode_i[11:9];
  assign rd_src_idx = opcode_i[2:0];

  // Execute unit
  m68kdx_exec u_exec (
    .opcode_i        (s1_opcode_q),
    .instr_address_i (s1_addr_q),
    .dst_val_i       (s1_dst_q),
    .src_val_i       (s1_src_q),
    .flags_i         (flags_q),
    .result_o        (ex_res),
    .rf_wr_o         (rf_wr)
  );

  // Stage 1 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (ex_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Stage 1 payload and operand read with bypass from the executing instruction
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_opcode_q <= opcode_i;
      s1_addr_q   <= instr_address_i;
      if (ex_fire && rf_wr.en && rf_wr.idx == rd_dst_idx) begin
        s1_dst_q <= rf_wr.data;
      end else begin
        s1_dst_q <= rf_vld_q[rd_dst_idx] ? rf_mem[rd_dst_idx] : '0;
      end
      if (ex_fire && rf_wr.en && rf_wr.idx == rd_src_idx) begin
        s1_src_q <= rf_wr.data;
      end else begin
        s1_src_q <= rf_vld_q[rd_src_idx] ? rf_mem[rd_src_idx] : '0;
      end
    end
  end

  // Data register storage
  always_ff @(posedge clk_i) begin
    if (ex_fire && rf_wr.en) begin
      rf_mem[rf_wr.idx] <= rf_wr.data;
    end
  end

  // Per-entry valid bits: an unwritten register reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
    end else if (ex_fire && rf_wr.en) begin
      rf_vld_q[rf_wr.idx] <= 1'b1;
    end
  end

  // Condition register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (ex_fire) begin
      flags_q <= ex_res.flags;
    end
  end

  // Result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ex_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (ex_fire) begin
      out_res_q <= ex_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign next_pc_o       = out_res_q.next_pc;
  assign branch_taken_o  = out_res_q.branch_taken;
  assign written_value_o = out_res_q.written_value;
  assign flags_out_o     = out_res_q.flags;
  assign unsupported_o   = out_res_q.unsupported;

endmodule

`default_nettype wire

[sim/m68k_subset_decode_execute_core_test.sv]
`timescale 1ns / 1ps

module m68k_subset_decode_execute_core_test;
  import m68kdx_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned MAX_ERR_LINES = 20;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [OP_W-1:0]   opcode_i;
  logic [DATA_W-1:0] instr_address_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [DATA_W-1:0] next_pc_o;
  logic              branch_taken_o;
  logic [DATA_W-1:0] written_value_o;
  logic [FLAG_W-1:0] flags_out_o;
  logic              unsupported_o;

  // Architectural state as the testbench sees it
  logic [DATA_W-1:0] shadow_regs [NUM_REGS];
  logic [FLAG_W-1:0] shadow_flags;

  ex_result_t        pending_results [$];
  logic [DATA_W-1:0] fetch_pc;
  bit                idle_off;
  int unsigned       instrs_sent;
  int unsigned       results_checked;
  int unsigned       taken_seen;
  int unsigned       unsup_seen;
  int unsigned       mismatch_count;
  int unsigned       cycle_count;

  m68k_subset_decode_execute_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .instr_address_i (instr_address_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .next_pc_o       (next_pc_o),
    .branch_taken_o  (branch_taken_o),
    .written_value_o (written_value_o),
    .flags_out_o     (flags_out_o),
    .unsupported_o   (unsupported_o)
  );

  // Clock
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Opcode builders
  function automatic logic [OP_W-1:0] alu_op(input logic [3:0] grp, input logic [2:0] opm,
                                             input logic [2:0] rh, input logic [2:0] rl);
    return {grp, rh, opm, EAMODE_DREG, rl};
  endfunction

  function automatic logic [OP_W-1:0] bcc_op(input logic [3:0] cc, input logic [7:0] disp);
    return {GRP_BCC, cc, disp};
  endfunction

  function automatic logic [OP_W-1:0] moveq_op(input logic [2:0] rh, input logic [7:0] imm);
    return {GRP_MOVEQ, rh, 1'b0, imm};
  endfunction

  // N and Z from a 32-bit result, everything else clear
  function automatic logic [FLAG_W-1:0] nz_bits(input logic [DATA_W-1:0] v);
    logic [FLAG_W-1:0] f;
    f = '0;
    f[FLAG_Z_BIT] = (v == '0);
    f[FLAG_N_BIT] = v[DATA_W-1];
    return f;
  endfunction

  function automatic logic branch_cond_met(input logic [3:0] cc, input logic [FLAG_W-1:0] f);
    logic n_xor_v;
    n_xor_v = f[FLAG_N_BIT] ^ f[FLAG_V_BIT];
    case (cc)
      CC_T:    return 1'b1;
      CC_F:    return 1'b0;
      CC_HI:   return ~(f[FLAG_C_BIT] | f[FLAG_Z_BIT]);
      CC_LS:   return f[FLAG_C_BIT] | f[FLAG_Z_BIT];
      CC_CC:   return ~f[FLAG_C_BIT];
      CC_CS:   return f[FLAG_C_BIT];
      CC_NE:   return ~f[FLAG_Z_BIT];
      CC_EQ:   return f[FLAG_Z_BIT];
      CC_VC:   return ~f[FLAG_V_BIT];
      CC_VS:   return f[FLAG_V_BIT];
      CC_PL:   return ~f[FLAG_N_BIT];
      CC_MI:   return f[FLAG_N_BIT];
      CC_GE:   return ~n_xor_v;
      CC_LT:   return n_xor_v;
      CC_GT:   return ~f[FLAG_Z_BIT] & ~n_xor_v;
      default: return f[FLAG_Z_BIT] | n_xor_v;
    endcase
  endfunction

  // Execute one instruction on the shadow state and give the result it must produce
  task automatic predict_execute(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] addr,
                                 output ex_result_t res);
    logic [3:0]        grp;
    logic [2:0]        rh;
    logic [2:0]        rl;
    logic [2:0]        opm;
    logic [2:0]        eam;
    logic [DATA_W-1:0] d;
    logic [DATA_W-1:0] s;
    logic [DATA_W-1:0] r;
    logic [DATA_W:0]   wide;
    logic [FLAG_W-1:0] f;
    logic              borrow;
    grp = op[15:12];
    rh  = op[11:9];
    opm = op[8:6];
    eam = op[5:3];
    rl  = op[2:0];
    d   = shadow_regs[rh];
    s   = shadow_regs[rl];
    res.next_pc       = addr + 32'd2;
    res.branch_taken  = 1'b0;
    res.written_value = '0;
    res.unsupported   = 1'b0;
    if (op == OPC_NOP) begin
      // nothing changes
    end else if (grp == GRP_MOVEQ && !op[8]) begin
      r = {{24{op[7]}}, op[7:0]};
      shadow_regs[rh] = r;
      res.written_value = r;
      shadow_flags = nz_bits(r) | (shadow_flags & (FLAG_W'(1) << FLAG_X_BIT));
    end else if (grp == GRP_MOVEL && opm == OPMODE_MOVE && eam == EAMODE_DREG) begin
      shadow_regs[rh] = s;
      res.written_value = s;
      shadow_flags = nz_bits(s) | (shadow_flags & (FLAG_W'(1) << FLAG_X_BIT));
    end else if (grp == GRP_ADD && opm == OPMODE_LONG && eam == EAMODE_DREG) begin
      wide = {1'b0, d} + {1'b0, s};
      r = wide[DATA_W-1:0];
      f = nz_bits(r);
      f[FLAG_C_BIT] = wide[DATA_W];
      f[FLAG_X_BIT] = wide[DATA_W];
      f[FLAG_V_BIT] = (d[31] == s[31]) && (r[31] != d[31]);
      shadow_regs[rh] = r;
      res.written_value = r;
      shadow_flags = f;
    end else if ((grp == GRP_SUB || grp == GRP_CMPEOR) && opm == OPMODE_LONG &&
                 eam == EAMODE_DREG) begin
      r = d - s;
      borrow = (s > d);
      f = nz_bits(r);
      f[FLAG_C_BIT] = borrow;
      f[FLAG_V_BIT] = (d[31] != s[31]) && (r[31] != d[31]);
      if (grp == GRP_SUB) begin
        f[FLAG_X_BIT] = borrow;
        shadow_regs[rh] = r;
        res.written_value = r;
      end else begin
        // compare keeps X and writes nothing
        f[FLAG_X_BIT] = shadow_flags[FLAG_X_BIT];
      end
      shadow_flags = f;
    end else if (grp == GRP_CMPEOR && opm == OPMODE_EOR && eam == EAMODE_DREG) begin
      r = d ^ s;
      shadow_regs[rl] = r;
      res.written_value = r;
      shadow_flags = nz_bits(r) | (shadow_flags & (FLAG_W'(1) << FLAG_X_BIT));
    end else if ((grp == GRP_AND || grp == GRP_OR) && opm == OPMODE_LONG &&
                 eam == EAMODE_DREG) begin
      r = (grp == GRP_AND) ? (d & s) : (d | s);
      shadow_regs[rh] = r;
      res.written_value = r;
      shadow_flags = nz_bits(r) | (shadow_flags & (FLAG_W'(1) << FLAG_X_BIT));
    end else if (grp == GRP_BCC && op[7:0] != DISP_WORD && op[7:0] != DISP_LONG &&
                 op[11:8] != CC_F) begin
      if (branch_cond_met(op[11:8], shadow_flags)) begin
        res.branch_taken = 1'b1;
        res.next_pc = addr + 32'd2 + {{24{op[7]}}, op[7:0]};
      end
    end else begin
      res.unsupported = 1'b1;
    end
    res.flags = shadow_flags;
  endtask

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (idle_off) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Send one instruction and record its expected result at acceptance
  task automatic send_instr(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] addr);
    int unsigned gap;
    ex_result_t  res;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    opcode_i        <= op;
    instr_address_i <= addr;
    do @(posedge clk_i); while (!in_ready_o);
    predict_execute(op, addr, res);
    pending_results = {pending_results, res};
    fetch_pc = res.next_pc;
    instrs_sent++;
  endtask

  // Stop sending and let every outstanding result come back
  task automatic wait_drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Mostly well-formed instructions with random registers, some noise and near misses
  function automatic logic [OP_W-1:0] random_instr();
    int unsigned r;
    logic [2:0]  rh;
    logic [2:0]  rl;
    r  = $urandom_range(0, 99);
    rh = 3'($urandom_range(0, 7));
    rl = 3'($urandom_range(0, 7));
    if (r < 12) return moveq_op(rh, 8'($urandom_range(0, 255)));
    if (r < 22) return alu_op(GRP_MOVEL, OPMODE_MOVE, rh, rl);
    if (r < 36) begin
      // doubling now and then drives values towards the 32-bit edges
      if ($urandom_range(0, 2) == 0) rl = rh;
      return alu_op(GRP_ADD, OPMODE_LONG, rh, rl);
    end
    if (r < 46) return alu_op(GRP_SUB, OPMODE_LONG, rh, rl);
    if (r < 54) return alu_op(GRP_CMPEOR, OPMODE_LONG, rh, rl);
    if (r < 60) return alu_op(GRP_CMPEOR, OPMODE_EOR, rh, rl);
    if (r < 66) return alu_op(GRP_AND, OPMODE_LONG, rh, rl);
    if (r < 72) return alu_op(GRP_OR, OPMODE_LONG, rh, rl);
    if (r < 85) return bcc_op(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
    if (r < 88) return OPC_NOP;
    if (r < 94) return alu_op($urandom_range(0, 1) ? GRP_ADD : GRP_OR, OPMODE_LONG, rh, rl) ^
                       (16'h1 << $urandom_range(0, 15));
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic logic [DATA_W-1:0] random_address();
    if ($urandom_range(0, 99) < 85) return fetch_pc;
    return $urandom();
  endfunction

  // Every instruction class, flag extremes, the unsupported corners
  task automatic test_directed();
    send_instr(OPC_NOP, 32'h0000_0000);
    send_instr(moveq_op(3'd0, 8'h00), fetch_pc);
    send_instr(moveq_op(3'd1, 8'hFF), fetch_pc);
    send_instr(moveq_op(3'd2, 8'h7F), fetch_pc);
    send_instr(moveq_op(3'd3, 8'h80), fetch_pc);
    // MOVEQ with bit 8 set is outside the subset
    send_instr({GRP_MOVEQ, 3'd7, 1'b1, 8'h55}, fetch_pc);
    send_instr(alu_op(GRP_ADD, OPMODE_LONG, 3'd1, 3'd1), fetch_pc);
    send_instr(alu_op(GRP_MOVEL, OPMODE_MOVE, 3'd4, 3'd2), fetch_pc);
    send_instr(alu_op(GRP_SUB, OPMODE_LONG, 3'd0, 3'd2), fetch_pc);
    send_instr(alu_op(GRP_CMPEOR, OPMODE_LONG, 3'd2, 3'd3), fetch_pc);
    send_instr(alu_op(GRP_AND, OPMODE_LONG, 3'd3, 3'd1), fetch_pc);
    send_instr(alu_op(GRP_OR, OPMODE_LONG, 3'd2, 3'd0), fetch_pc);
    send_instr(alu_op(GRP_CMPEOR, OPMODE_EOR, 3'd1, 3'd4), fetch_pc);
    send_instr(moveq_op(3'd5, 8'h00), fetch_pc);
    send_instr(bcc_op(CC_EQ, 8'h10), 32'h0000_1000);
    send_instr(bcc_op(CC_NE, 8'h80), fetch_pc);
    send_instr(bcc_op(CC_T, 8'h80), 32'h0000_2000);
    // target wraps past the top of the address space
    send_instr(bcc_op(CC_T, 8'h7E), 32'hFFFF_FFFE);
    // word and long displacement forms need extension words
    send_instr(bcc_op(CC_T, DISP_WORD), fetch_pc);
    send_instr(bcc_op(CC_GT, DISP_LONG), fetch_pc);
    // BSR
    send_instr(bcc_op(CC_F, 8'h04), fetch_pc);
    send_instr(16'hFFFF, fetch_pc);
    send_instr(16'h0000, 32'hFFFF_FFFF);
    // MOVE.L from an address register
    send_instr({GRP_MOVEL, 3'd0, OPMODE_MOVE, 3'd1, 3'd0}, fetch_pc);
    send_instr(alu_op(GRP_SUB, OPMODE_LONG, 3'd5, 3'd5), fetch_pc);
  endtask

  task automatic test_random_stream(input int unsigned count);
    repeat (count) send_instr(random_instr(), random_address());
  endtask

  // Sender holds off until the pipeline is empty, then restarts
  task automatic test_drain_pause();
    repeat (3) begin
      test_random_stream(10);
      wait_drain();
    end
  endtask

  // No idling on either side
  task automatic test_back_to_back(input int unsigned count);
    idle_off = 1'b1;
    test_random_stream(count);
    idle_off = 1'b0;
  endtask

  // Receiver: bursts of ready broken by stalls
  initial begin : drive_out_ready
    int unsigned burst;
    int unsigned stall;
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      if (idle_off) begin
        @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        burst = $urandom_range(1, 16);
        @(negedge clk_i);
        out_ready_i <= 1'b1;
        repeat (burst - 1) @(negedge clk_i);
        stall = pick_gap();
        if (stall > 0) begin
          @(negedge clk_i);
          out_ready_i <= 1'b0;
          repeat (stall - 1) @(negedge clk_i);
        end
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    if (mismatch_count < MAX_ERR_LINES)
      $display("error @%0t result %0d: %s got %h want %h", $realtime, results_checked, what,
               got, want);
    mismatch_count++;
  endtask

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin : check_results
    ex_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, next_pc", next_pc_o, '0);
      end else begin
        want = pending_results.pop_front();
        if (next_pc_o !== want.next_pc)
          report_mismatch("next_pc", next_pc_o, want.next_pc);
        if (branch_taken_o !== want.branch_taken)
          report_mismatch("branch_taken", DATA_W'(branch_taken_o),
                          DATA_W'(want.branch_taken));
        if (written_value_o !== want.written_value)
          report_mismatch("written_value", written_value_o, want.written_value);
        if (flags_out_o !== want.flags)
          report_mismatch("flags_out", DATA_W'(flags_out_o), DATA_W'(want.flags));
        if (unsupported_o !== want.unsupported)
          report_mismatch("unsupported", DATA_W'(unsupported_o),
                          DATA_W'(want.unsupported));
        if (want.branch_taken) taken_seen++;
        if (want.unsupported) unsup_seen++;
      end
      results_checked++;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Test sequence
  initial begin
    for (int i = 0; i < NUM_REGS; i++) shadow_regs[i] = '0;
    shadow_flags    = '0;
    fetch_pc        = '0;
    idle_off        = 1'b0;
    instrs_sent     = 0;
    results_checked = 0;
    taken_seen      = 0;
    unsup_seen      = 0;
    mismatch_count  = 0;
    cycle_count     = 0;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    opcode_i        = '0;
    instr_address_i = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_stream(250);
    test_drain_pause();
    test_back_to_back(150);
    test_random_stream(120);

    wait_drain();
    repeat (8) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", pending_results.size(), '0);

    $display("covered %0d instructions, %0d results checked (%0d taken branches, %0d unsupported)",
             instrs_sent, results_checked, taken_seen, unsup_seen);
    $display("with idle gaps and stalls on both sides, a drain pause and a back-to-back stretch");
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
